@@ rtl/core/ppp_pkg.sv @@
// -----------------------------------------------------------------------------
// ppp_pkg
// Widths and register indexes shared by the point-to-plane projection core.
// -----------------------------------------------------------------------------
package ppp_pkg;

	localparam int FRAC_BITS = 16;              // Q format of points and distance
	localparam int PW        = 32;              // point coordinate width
	localparam int NW        = 16;              // normal component width
	localparam int DW        = 50;              // plane offset width
	localparam int SW        = 51;              // signed distance width
	localparam int PRW       = NW + PW;         // n_i * p_i product width
	localparam int L2W       = 32;              // |n|^2 width
	localparam int QW        = SW;              // dividend / quotient width
	localparam int TBW       = 33;              // |t| below 2^TBW can stay in range
	localparam int TW        = TBW + 2;         // signed t after range check
	localparam int NTW       = NW + TW;         // n_i * t width
	localparam int CIW       = 2;               // config index width
	localparam int CDW       = DW;              // config data width

	typedef enum logic [CIW-1:0] {
		REG_NORMAL_X = 2'd0,
		REG_NORMAL_Y = 2'd1,
		REG_NORMAL_Z = 2'd2,
		REG_OFFSET   = 2'd3
	} cfg_reg_t;

	localparam logic signed [PW-1:0] S32_MAX = {1'b0, {(PW-1){1'b1}}};
	localparam logic signed [PW-1:0] S32_MIN = {1'b1, {(PW-1){1'b0}}};

endpackage

@@ rtl/core/point_plane_projection_top.sv @@
// Pipeline: an accepted point passes 3 entry stages, one restoring divider
// stage per quotient bit (51) and 2 projection stages on the way to its result.
// Throughput: one point per cycle unless stalled; 51-stage divider sets depth.
// A stalled output holds the whole pipeline, and input stall follows it.
// Reset (arst_n low, asynchronous): pipeline empty, normal = (0,0,1), offset 0.
// -----------------------------------------------------------------------------
// point_plane_projection_top
// Signed distance of a Q16.16 point to a plane and its orthogonal projection.
// -----------------------------------------------------------------------------
module point_plane_projection_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ppp_pkg::CIW-1:0]             cfg_idx,
	input  logic [ppp_pkg::CDW-1:0]             cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [ppp_pkg::PW-1:0]       point_x,
	input  logic signed [ppp_pkg::PW-1:0]       point_y,
	input  logic signed [ppp_pkg::PW-1:0]       point_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [ppp_pkg::PW-1:0]       proj_x,
	output logic signed [ppp_pkg::PW-1:0]       proj_y,
	output logic signed [ppp_pkg::PW-1:0]       proj_z,
	output logic signed [ppp_pkg::SW-1:0]       signed_distance,
	output logic                                above,
	output logic                                degenerate
);

	localparam int PW  = ppp_pkg::PW;
	localparam int NW  = ppp_pkg::NW;
	localparam int SW  = ppp_pkg::SW;
	localparam int PRW = ppp_pkg::PRW;
	localparam int L2W = ppp_pkg::L2W;
	localparam int QW  = ppp_pkg::QW;
	localparam int TBW = ppp_pkg::TBW;
	localparam int TW  = ppp_pkg::TW;
	localparam int NTW = ppp_pkg::NTW;

	// configuration
	logic signed [NW-1:0]          nx_q, ny_q, nz_q;
	logic signed [ppp_pkg::DW-1:0] d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q <= '0;
			ny_q <= '0;
			nz_q <= NW'(1);
			d_q  <= '0;
		end else if (cfg_we) begin
			unique case (ppp_pkg::cfg_reg_t'(cfg_idx))
				ppp_pkg::REG_NORMAL_X: nx_q <= cfg_data[NW-1:0];
				ppp_pkg::REG_NORMAL_Y: ny_q <= cfg_data[NW-1:0];
				ppp_pkg::REG_NORMAL_Z: nz_q <= cfg_data[NW-1:0];
				ppp_pkg::REG_OFFSET:   d_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline advances unless the result beat is held
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: products
	logic                  vld_s1;
	logic signed [PW-1:0]  px_s1, py_s1, pz_s1;
	logic signed [PRW-1:0] prx_s1, pry_s1, prz_s1;
	logic [L2W-1:0]        sqx_s1, sqy_s1, sqz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1  <= point_x;
			py_s1  <= point_y;
			pz_s1  <= point_z;
			prx_s1 <= PRW'(nx_q) * PRW'(point_x);
			pry_s1 <= PRW'(ny_q) * PRW'(point_y);
			prz_s1 <= PRW'(nz_q) * PRW'(point_z);
			sqx_s1 <= L2W'(nx_q) * L2W'(nx_q);
			sqy_s1 <= L2W'(ny_q) * L2W'(ny_q);
			sqz_s1 <= L2W'(nz_q) * L2W'(nz_q);
		end
	end

	// stage 2: distance and squared length
	logic                 vld_s2;
	logic signed [PW-1:0] px_s2, py_s2, pz_s2;
	logic signed [SW-1:0] s_s2;
	logic [L2W-1:0]       len2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s2   <= px_s1;
			py_s2   <= py_s1;
			pz_s2   <= pz_s1;
			s_s2    <= SW'(prx_s1) + SW'(pry_s1) + SW'(prz_s1) + SW'(d_q);
			len2_s2 <= sqx_s1 + sqy_s1 + sqz_s1;
		end
	end

	// divider pipeline: index 0 is loaded from stage 2, index QW feeds stage 4
	logic                 vld_sd  [QW+1];
	logic signed [PW-1:0] px_sd   [QW+1];
	logic signed [PW-1:0] py_sd   [QW+1];
	logic signed [PW-1:0] pz_sd   [QW+1];
	logic signed [SW-1:0] s_sd    [QW+1];
	logic [L2W-1:0]       len2_sd [QW+1];
	logic [QW-1:0]        dq_sd   [QW+1];
	logic [L2W-1:0]       rem_sd  [QW+1];

	// stage 3: magnitude of the dividend
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sd[0] <= 1'b0;
		else if (adv) vld_sd[0] <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_sd[0]   <= px_s2;
			py_sd[0]   <= py_s2;
			pz_sd[0]   <= pz_s2;
			s_sd[0]    <= s_s2;
			len2_sd[0] <= len2_s2;
			dq_sd[0]   <= s_s2[SW-1] ? QW'(-s_s2) : QW'(s_s2);
			rem_sd[0]  <= '0;
		end
	end

	// one restoring step per stage: dividend shifts out, quotient bit shifts in
	for (genvar i = 0; i < QW; i++) begin : g_div
		logic [L2W:0] shl;
		logic         ge;

		assign shl = {rem_sd[i], dq_sd[i][QW-1]};
		assign ge  = shl >= {1'b0, len2_sd[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_sd[i+1] <= 1'b0;
			else if (adv) vld_sd[i+1] <= vld_sd[i];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				px_sd[i+1]   <= px_sd[i];
				py_sd[i+1]   <= py_sd[i];
				pz_sd[i+1]   <= pz_sd[i];
				s_sd[i+1]    <= s_sd[i];
				len2_sd[i+1] <= len2_sd[i];
				dq_sd[i+1]   <= {dq_sd[i][QW-2:0], ge};
				rem_sd[i+1]  <= ge ? L2W'(shl - {1'b0, len2_sd[i]}) : L2W'(shl);
			end
		end
	end

	// stage 4: signed quotient and corrections n_i * t
	logic                 vld_s4, big_s4, neg_s4, degen_s4;
	logic signed [PW-1:0] px_s4, py_s4, pz_s4;
	logic signed [SW-1:0] s_s4;
	logic signed [NTW-1:0] ntx_s4, nty_s4, ntz_s4;
	logic [QW-1:0]        q_d;
	logic signed [TW-1:0] t_d;

	assign q_d = dq_sd[QW];
	assign t_d = s_sd[QW][SW-1] ? -$signed({2'b00, q_d[TBW-1:0]})
	                            :  $signed({2'b00, q_d[TBW-1:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (adv) vld_s4 <= vld_sd[QW];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s4    <= px_sd[QW];
			py_s4    <= py_sd[QW];
			pz_s4    <= pz_sd[QW];
			s_s4     <= s_sd[QW];
			neg_s4   <= s_sd[QW][SW-1];
			degen_s4 <= (len2_sd[QW] == '0);
			// beyond this magnitude every non-zero n_i pushes the result out of range
			big_s4   <= |q_d[QW-1:TBW];
			ntx_s4   <= NTW'(nx_q) * NTW'(t_d);
			nty_s4   <= NTW'(ny_q) * NTW'(t_d);
			ntz_s4   <= NTW'(nz_q) * NTW'(t_d);
		end
	end

	// stage 5: subtract, saturate, output register
	function automatic logic signed [PW-1:0] proj_axis(
		input logic signed [PW-1:0]  p,
		input logic signed [NW-1:0]  n,
		input logic signed [NTW-1:0] nt,
		input logic                  big,
		input logic                  neg,
		input logic                  degen
	);
		logic signed [NTW:0] diff;
		diff = (NTW+1)'(p) - (NTW+1)'(nt);
		if (degen || n == '0) return p;
		if (big) return (n[NW-1] == neg) ? ppp_pkg::S32_MIN : ppp_pkg::S32_MAX;
		if (diff > (NTW+1)'(ppp_pkg::S32_MAX)) return ppp_pkg::S32_MAX;
		if (diff < (NTW+1)'(ppp_pkg::S32_MIN)) return ppp_pkg::S32_MIN;
		return PW'(diff);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			proj_x          <= proj_axis(px_s4, nx_q, ntx_s4, big_s4, neg_s4, degen_s4);
			proj_y          <= proj_axis(py_s4, ny_q, nty_s4, big_s4, neg_s4, degen_s4);
			proj_z          <= proj_axis(pz_s4, nz_q, ntz_s4, big_s4, neg_s4, degen_s4);
			signed_distance <= s_s4;
			above           <= !s_s4[SW-1] && (s_s4 != '0);
			degenerate      <= degen_s4;
		end
	end

`ifndef SYNTHESIS
	a_above: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (above == (signed_distance > 0)))
		else $error("above flag disagrees with distance");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall not tied to held result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_sd[QW/2]) && $stable(dq_sd[QW/2]))
		else $error("divider stage moved while held");

	a_degen_dist: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && adv |=> out_valid && (degenerate == $past(degen_s4)))
		else $error("result beat lost at output");
`endif

endmodule
